@@ design/htw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg
// Types, codes and slot arithmetic for the four-level timing wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

   localparam int HTW_TIMER_COUNT = 64;
   localparam logic [47:0] HTW_AHEAD_LIMIT = 48'hFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_DELETE  = 2'd1,
      OP_ADVANCE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_DELETE  = 2'd1,
      KIND_EXPIRED = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_GRANULE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MIN,
      S_EXPIRE,
      S_CASCADE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  timer_id;
      logic [47:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] status;
      logic [5:0] expired_id;
      logic       last;
   } rsp_type;

   // deadline granule bits 27..4 and level:slot
   typedef struct packed {
      logic [23:0] dl;
      logic [7:0]  ls;
   } entry_type;

   typedef struct packed {
      logic       found;
      logic [7:0] ls;
   } slot_pick_type;

   function automatic slot_pick_type choose_slot(logic [23:0] dl, logic [23:0] ctr);
      slot_pick_type p;
      p.found = 1'b0;
      p.ls    = 8'd0;
      for (int l = 0; l < 4; l++) begin
         if (dl[6*l +: 6] != ctr[6*l +: 6]) begin
            p.found = 1'b1;
            p.ls    = {2'(l), dl[6*l +: 6]};
         end
      end
      return p;
   endfunction

   // granules until the slot is reached
   function automatic logic [23:0] time_to_slot(logic [7:0] ls, logic [23:0] ctr);
      logic [5:0]  s;
      logic [23:0] k;
      logic [23:0] tt;
      s  = ls[5:0];
      k  = 24'd0;
      tt = 24'd0;
      case (ls[7:6])
         2'd0: begin
            tt = {18'd0, 6'(s - ctr[5:0])};
         end
         2'd1: begin
            k  = {12'd0, 12'({s, 6'd0} - ctr[11:0])};
            tt = (k == 24'd0) ? 24'h000FFF : k - 24'd1;
         end
         2'd2: begin
            k  = {6'd0, 18'({s, 12'd0} - ctr[17:0])};
            tt = (k == 24'd0) ? 24'h03FFFF : k - 24'd1;
         end
         default: begin
            k  = 24'({s, 18'd0} - ctr);
            tt = (k == 24'd0) ? 24'hFFFFFF : k - 24'd1;
         end
      endcase
      return tt;
   endfunction

endpackage

@@ design/hierarchical_timing_wheel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel
// Add and delete: result registered, in the cycle after start; one item per
// cycle while idle. Advance: each step scans the entry memory in passes
// through its single read port; per expiry event one min pass, one expire
// pass and up to three cascade passes. Results are single-cycle strobes.
// Reset: synchronous; time 0, all timers inactive, no clearing pass.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel
   import htw_pkg::*;
#(
   parameter int TIMER_COUNT = HTW_TIMER_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [47:0] csr_data
);

   localparam int IDX_W = $clog2(TIMER_COUNT);
   localparam logic [IDX_W:0]   TC_CNT   = (IDX_W+1)'(TIMER_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
   localparam logic [6:0]       TC_ID    = 7'(TIMER_COUNT);

   state_type            state_ff, state_in;
   logic [23:0]          ctr_ff, ctr_in;
   logic [47:0]          cur_ff, cur_in;
   logic [47:0]          tgt_ff, tgt_in;
   logic [23:0]          r_ff, r_in;
   logic [23:0]          best_ff, best_in;
   logic [IDX_W:0]       cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [1:0]           lvl_ff, lvl_in;
   logic [5:0]           pend_ff, pend_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [5:0]           echo_ff, echo_in;
   logic [TIMER_COUNT-1:0] active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   entry_type            mem_wdata;
   entry_type            mem_rdata;

   logic [47:0]          diff;
   logic                 in_range;
   logic                 id_oob;
   logic                 scan_issue;
   logic                 scan_end;
   logic                 hit_act;
   logic [23:0]          tt;
   logic [23:0]          best_now;
   logic [23:0]          ctr_nxt;
   slot_pick_type        pick_add;
   slot_pick_type        pick_cas;
   logic [7:0]           cas_target;

   htw_entry_mem #(
      .TIMER_COUNT(TIMER_COUNT)
   ) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(cnt_ff[IDX_W-1:0]),
      .rdata(mem_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign diff       = req_item.time_ms - cur_ff;
   assign in_range   = (req_item.time_ms >= cur_ff) && (diff <= HTW_AHEAD_LIMIT);
   assign id_oob     = ({1'b0, req_item.timer_id} >= TC_ID);
   assign scan_issue = (cnt_ff < TC_CNT);
   assign scan_end   = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign hit_act    = rd_vld_ff && active_ff[rd_idx_ff];
   assign tt         = time_to_slot(mem_rdata.ls, ctr_ff);
   assign best_now   = (hit_act && (tt < best_ff)) ? tt : best_ff;
   assign ctr_nxt    = ctr_ff + 24'd1;
   assign pick_add   = choose_slot(req_item.time_ms[27:4], ctr_ff);
   assign pick_cas   = choose_slot(mem_rdata.dl, ctr_ff);
   assign cas_target = {lvl_ff, ctr_ff[6*lvl_ff +: 6]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctr_ff       <= 24'd0;
         cur_ff       <= 48'd0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         cur_ff       <= cur_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         pend_vld_ff  <= pend_vld_in;
         cnt_ff       <= cnt_in;
      end
      tgt_ff    <= tgt_in;
      r_ff      <= r_in;
      best_ff   <= best_in;
      rd_idx_ff <= rd_idx_in;
      lvl_ff    <= lvl_in;
      pend_ff   <= pend_in;
      echo_ff   <= echo_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      r_in         = r_ff;
      best_in      = best_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = cnt_ff[IDX_W-1:0];
      lvl_in       = lvl_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      echo_in      = echo_ff;
      active_in    = active_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = rd_idx_ff;
      mem_wdata    = mem_rdata;

      if (state_ff == S_MIN || state_ff == S_EXPIRE || state_ff == S_CASCADE) begin
         rd_vld_in = scan_issue;
         if (scan_issue) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               cur_in = csr_data;
               ctr_in = csr_data[27:4];
            end
            if (start) begin
               rsp_in.expired_id = req_item.timer_id;
               rsp_in.last       = 1'b1;
               rsp_in.status     = ST_OK;
               case (req_item.operation)
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = KIND_ADD;
                     if (!in_range || id_oob) begin
                        rsp_in.status = ST_RANGE;
                     end else if (!pick_add.found) begin
                        rsp_in.status = ST_GRANULE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = req_item.timer_id[IDX_W-1:0];
                        mem_wdata = '{dl: req_item.time_ms[27:4], ls: pick_add.ls};
                        active_in[req_item.timer_id[IDX_W-1:0]] = 1'b1;
                     end
                  end
                  OP_ADVANCE: begin
                     if (!in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.kind   = KIND_DONE;
                        rsp_in.status = ST_RANGE;
                     end else begin
                        r_in        = diff[27:4];
                        tgt_in      = req_item.time_ms;
                        echo_in     = req_item.timer_id;
                        pend_vld_in = 1'b0;
                        state_in    = S_CHECK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = KIND_DELETE;
                     if (!id_oob) begin
                        active_in[req_item.timer_id[IDX_W-1:0]] = 1'b0;
                     end
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (r_ff == 24'd0) begin
               state_in = S_FINISH;
            end else begin
               best_in  = r_ff;
               cnt_in   = '0;
               state_in = S_MIN;
            end
         end
         S_MIN: begin
            best_in = best_now;
            if (scan_end) begin
               if (best_now >= r_ff) begin
                  ctr_in   = ctr_ff + r_ff;
                  state_in = S_FINISH;
               end else begin
                  ctr_in   = ctr_ff + best_now;
                  r_in     = r_ff - best_now;
                  cnt_in   = '0;
                  state_in = S_EXPIRE;
               end
            end
         end
         S_EXPIRE: begin
            if (hit_act && (mem_rdata.ls == {2'd0, ctr_ff[5:0]})) begin
               active_in[rd_idx_ff] = 1'b0;
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{kind: KIND_EXPIRED, status: ST_OK,
                                   expired_id: pend_ff, last: 1'b0};
               end
               pend_in     = 6'(rd_idx_ff);
               pend_vld_in = 1'b1;
            end
            if (scan_end) begin
               ctr_in = ctr_nxt;
               r_in   = r_ff - 24'd1;
               cnt_in = '0;
               if (ctr_nxt[17:0] == 18'd0) begin
                  lvl_in   = 2'd3;
                  state_in = S_CASCADE;
               end else if (ctr_nxt[11:0] == 12'd0) begin
                  lvl_in   = 2'd2;
                  state_in = S_CASCADE;
               end else if (ctr_nxt[5:0] == 6'd0) begin
                  lvl_in   = 2'd1;
                  state_in = S_CASCADE;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CASCADE: begin
            if (hit_act && (mem_rdata.ls == cas_target)) begin
               mem_we       = 1'b1;
               mem_wdata.ls = pick_cas.found ? pick_cas.ls : {2'd0, ctr_ff[5:0]};
            end
            if (scan_end) begin
               if (lvl_ff == 2'd1) begin
                  state_in = S_CHECK;
               end else begin
                  lvl_in = lvl_ff - 2'd1;
                  cnt_in = '0;
               end
            end
         end
         S_FINISH: begin
            cur_in       = tgt_ff;
            rsp_valid_in = 1'b1;
            if (pend_vld_ff) begin
               rsp_in = '{kind: KIND_EXPIRED, status: ST_OK,
                          expired_id: pend_ff, last: 1'b1};
            end else begin
               rsp_in = '{kind: KIND_DONE, status: ST_OK,
                          expired_id: echo_ff, last: 1'b1};
            end
            pend_vld_in = 1'b0;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ design/htw_entry_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_entry_mem
// Timer entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module htw_entry_mem
   import htw_pkg::*;
#(
   parameter int TIMER_COUNT = HTW_TIMER_COUNT
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(TIMER_COUNT)-1:0] waddr,
   input  entry_type                      wdata,
   input  logic [$clog2(TIMER_COUNT)-1:0] raddr,
   output entry_type                      rdata
);

   entry_type mem [TIMER_COUNT];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
